/* rtl/vaq_pkg.sv */
// Shared types, constants and helpers for the voice allocation queue.
// Depends on nothing; used by the top level and the testbench.
`timescale 1ns / 1ps

package vaq_pkg;

   // Queue geometry
   localparam int VOICES = 6;
   localparam int CHIPS  = 4;
   localparam int HALF   = VOICES / 2;
   localparam int POS_W  = $clog2(VOICES);
   localparam int ROW_W  = (CHIPS > 1) ? $clog2(CHIPS) : 1;

   // Remainder unit: two dividend bits per step over an 8-bit dividend
   localparam int MOD_STEPS = 4;
   localparam int STEP_W    = 2;

   localparam logic [7:0] NO_INSTRUMENT = 8'hff;

   // Assignment modes
   localparam logic [7:0] ASG_ALL       = 8'd0;
   localparam logic [7:0] ASG_LEFT      = 8'd1;
   localparam logic [7:0] ASG_RIGHT     = 8'd2;
   localparam logic [7:0] ASG_DEDICATED = 8'd3;

   // Voice masks, one bit per voice number
   localparam logic [7:0] MASK_ALL   = 8'((1 << VOICES) - 1);
   localparam logic [7:0] MASK_LEFT  = 8'((1 << HALF) - 1);
   localparam logic [7:0] MASK_RIGHT = 8'(((1 << HALF) - 1) << HALF);

   typedef enum logic [1:0] {
      ACT_GET      = 2'd0,
      ACT_GET_LAST = 2'd1,
      ACT_RELEASE  = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef struct packed {
      logic [2:0] voice;
      logic       assigned;
      logic       exclusive;
      logic [7:0] instrument;
   } entry_type;

   typedef entry_type [VOICES-1:0] row_type;

   // Row contents after reset: entry i holds voice i, no instrument, flags clear
   function automatic row_type reset_row();
      row_type r;
      for (int i = 0; i < VOICES; i++) begin
         r[i].voice      = 3'(i);
         r[i].assigned   = 1'b0;
         r[i].exclusive  = 1'b0;
         r[i].instrument = NO_INSTRUMENT;
      end
      return r;
   endfunction

endpackage

/* rtl/vaq_req_if.sv */
// Request channel of the voice allocation queue: valid/ready plus request fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface vaq_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [1:0] chip;
   logic [7:0] instrument;
   logic [7:0] assign_mode;
   logic [3:0] voice_count;
   logic [2:0] target_voice;

   modport source (output valid, action, chip, instrument, assign_mode,
                   voice_count, target_voice, input ready);
   modport sink   (input valid, action, chip, instrument, assign_mode,
                   voice_count, target_voice, output ready);
endinterface

/* rtl/vaq_rsp_if.sv */
// Response channel of the voice allocation queue: valid/ready plus result fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface vaq_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] voice;
   logic       fallback;

   modport source (output valid, voice, fallback, input ready);
   modport sink   (input valid, voice, fallback, output ready);
endinterface

/* rtl/voice_allocation_queue_top.sv */
// Voice allocation queue top level: row memory, remainder unit and update logic.
// Depends on vaq_pkg, vaq_req_if and vaq_rsp_if.
`timescale 1ns / 1ps

// Usage
//  - req_ch carries one transaction per request: get, get-last or release on
//    the queue of one chip. rsp_ch returns exactly one transaction per request
//    with the voice number and a fallback flag (voice 0 when set).
//  - Each chip's queue is one row of a synchronous memory. A request reads its
//    row at acceptance, runs the dedicated-voice remainder (two dividend bits
//    per cycle), then updates the row and loads the response register in the
//    same cycle that writes the row back.
//  - Requests are taken one at a time, and a new request is accepted while the
//    previous response still waits in its output register.
//  - A stalled receiver holds the response; a finished update then waits
//    before writing back until the response register is free.
//  - Reset is synchronous and clears the control state and the per-row valid
//    bits; a row that was never written reads as its reset contents (voice i
//    at place i, no instrument, flags clear), so no clearing pass is needed.

module voice_allocation_queue_top (
   input  logic        clock,
   input  logic        reset,
   vaq_req_if.sink     req_ch,
   vaq_rsp_if.source   rsp_ch
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;

   // Row memory and its valid bits
   vaq_pkg::row_type               mem [vaq_pkg::CHIPS];
   logic [vaq_pkg::CHIPS-1:0]      row_valid_ff;
   vaq_pkg::row_type               row_rd_ff;
   logic                           row_ok_ff;

   // Captured request
   logic [1:0]                     action_ff;
   logic [1:0]                     chip_ff;
   logic [7:0]                     instr_ff;
   logic [7:0]                     asg_ff;
   logic [3:0]                     cnt_raw_ff;
   logic [3:0]                     cnt_ff;
   logic [2:0]                     target_ff;

   // Remainder unit
   logic [7:0]                     div_ff, div_in;
   logic [2:0]                     rem_ff, rem_in;
   logic [vaq_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [3:0]                     part1, part2;

   // Response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [2:0]                     rsp_voice_ff, rsp_voice_in;
   logic                           rsp_fallback_ff, rsp_fallback_in;

   logic                           accept;
   logic                           fire;
   logic [vaq_pkg::ROW_W-1:0]      req_row;
   logic [vaq_pkg::ROW_W-1:0]      cur_row;
   logic [3:0]                     cnt_clamped;

   // Update datapath
   vaq_pkg::row_type               eff_row;
   vaq_pkg::row_type               new_row;
   vaq_pkg::entry_type             moved;
   logic [7:0]                     mask;
   logic                           dedicated;
   logic [vaq_pkg::VOICES-1:0]     elig;
   logic [vaq_pkg::VOICES-1:0]     tgt_match;
   logic [vaq_pkg::POS_W-1:0]      get_pos;
   logic [vaq_pkg::POS_W-1:0]      tgt_pos;
   logic [vaq_pkg::POS_W-1:0]      move_pos;
   logic                           get_hit;
   logic                           tgt_hit;
   logic                           reuse;
   logic                           do_move;
   logic                           chip_ok;
   logic                           row_write;
   logic [2:0]                     out_voice;
   logic                           out_fallback;

   assign accept  = req_ch.valid && req_ch.ready;
   assign req_row = vaq_pkg::ROW_W'(req_ch.chip);
   assign cur_row = vaq_pkg::ROW_W'(chip_ff);

   // Clamp the count to the queue size; zero counts as one
   always_comb begin
      if (req_ch.voice_count > 4'(vaq_pkg::VOICES)) begin
         cnt_clamped = 4'(vaq_pkg::VOICES);
      end else if (req_ch.voice_count == 4'd0) begin
         cnt_clamped = 4'd1;
      end else begin
         cnt_clamped = req_ch.voice_count;
      end
   end

   // Remainder step: fold in two dividend bits, subtract the count at most once each
   always_comb begin
      part1 = {rem_ff, div_ff[7]};
      if (part1 >= cnt_ff) begin
         part1 = part1 - cnt_ff;
      end
      part2 = {part1[2:0], div_ff[6]};
      if (part2 >= cnt_ff) begin
         part2 = part2 - cnt_ff;
      end
   end

   // Update of the row read for this transaction
   always_comb begin
      eff_row   = row_ok_ff ? row_rd_ff : vaq_pkg::reset_row();
      dedicated = (asg_ff >= vaq_pkg::ASG_DEDICATED);
      chip_ok   = (32'(chip_ff) < vaq_pkg::CHIPS);

      case (asg_ff)
         vaq_pkg::ASG_ALL:   mask = vaq_pkg::MASK_ALL;
         vaq_pkg::ASG_LEFT:  mask = vaq_pkg::MASK_LEFT;
         vaq_pkg::ASG_RIGHT: mask = (cnt_ff <= 4'(vaq_pkg::HALF)) ? vaq_pkg::MASK_LEFT
                                                                  : vaq_pkg::MASK_RIGHT;
         default:            mask = 8'd1 << rem_ff;
      endcase

      // Candidates for a get and the place of the target voice
      for (int i = 0; i < vaq_pkg::VOICES; i++) begin
         elig[i]      = mask[eff_row[i].voice] &&
                        (!eff_row[i].exclusive || eff_row[i].instrument == instr_ff ||
                         dedicated);
         tgt_match[i] = (eff_row[i].voice == target_ff);
      end
      get_hit = |elig;
      tgt_hit = |tgt_match;
      get_pos = '0;
      tgt_pos = '0;
      for (int i = vaq_pkg::VOICES - 1; i >= 0; i--) begin
         if (elig[i]) begin
            get_pos = vaq_pkg::POS_W'(i);
         end
         if (tgt_match[i]) begin
            tgt_pos = vaq_pkg::POS_W'(i);
         end
      end

      reuse = (action_ff == vaq_pkg::ACT_GET_LAST) && tgt_hit &&
              (eff_row[tgt_pos].instrument == instr_ff) &&
              ({1'b0, target_ff} < cnt_raw_ff);

      new_row      = eff_row;
      moved        = eff_row[tgt_pos];
      move_pos     = tgt_pos;
      do_move      = 1'b0;
      out_voice    = 3'd0;
      out_fallback = 1'b1;

      if (chip_ok) begin
         if (action_ff == vaq_pkg::ACT_RELEASE) begin
            if (tgt_hit) begin
               new_row[tgt_pos].assigned = 1'b0;
               out_voice    = target_ff;
               out_fallback = 1'b0;
            end
         end else if (reuse) begin
            moved.assigned = 1'b1;
            do_move        = 1'b1;
         end else if ((action_ff == vaq_pkg::ACT_GET ||
                       action_ff == vaq_pkg::ACT_GET_LAST) && get_hit) begin
            moved.voice      = eff_row[get_pos].voice;
            moved.assigned   = 1'b1;
            moved.exclusive  = dedicated;
            moved.instrument = instr_ff;
            move_pos         = get_pos;
            do_move          = 1'b1;
         end
      end

      // Move the taken entry to the tail, close the gap behind it
      if (do_move) begin
         for (int i = 0; i < vaq_pkg::VOICES - 1; i++) begin
            if (vaq_pkg::POS_W'(i) >= move_pos) begin
               new_row[i] = eff_row[i + 1];
            end
         end
         new_row[vaq_pkg::VOICES-1] = moved;
         out_voice    = moved.voice;
         out_fallback = 1'b0;
      end
   end

   // Control: sequence one transaction at a time
   always_comb begin
      state_in        = state_ff;
      div_in          = div_ff;
      rem_in          = rem_ff;
      step_in         = step_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_voice_in    = rsp_voice_ff;
      rsp_fallback_in = rsp_fallback_ff;
      fire            = 1'b0;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               div_in   = req_ch.assign_mode - vaq_pkg::ASG_DEDICATED;
               rem_in   = 3'd0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = part2[2:0];
            div_in  = {div_ff[5:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == vaq_pkg::STEP_W'(vaq_pkg::MOD_STEPS - 1)) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // Hold until the response register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               fire            = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_voice_in    = out_voice;
               rsp_fallback_in = out_fallback;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign row_write = fire && chip_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         row_valid_ff    <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (row_write) begin
            row_valid_ff[cur_row] <= 1'b1;
         end
      end
      rsp_voice_ff    <= rsp_voice_in;
      rsp_fallback_ff <= rsp_fallback_in;
      div_ff          <= div_in;
      rem_ff          <= rem_in;
      step_ff         <= step_in;
   end

   // Capture the request and read its row
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff  <= req_ch.action;
         chip_ff    <= req_ch.chip;
         instr_ff   <= req_ch.instrument;
         asg_ff     <= req_ch.assign_mode;
         cnt_raw_ff <= req_ch.voice_count;
         cnt_ff     <= cnt_clamped;
         target_ff  <= req_ch.target_voice;
         row_rd_ff  <= mem[req_row];
         row_ok_ff  <= row_valid_ff[req_row];
      end
   end

   // Write back the updated row
   always_ff @(posedge clock) begin
      if (row_write) begin
         mem[cur_row] <= new_row;
      end
   end

   assign req_ch.ready    = (state_ff == ST_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.voice    = rsp_voice_ff;
   assign rsp_ch.fallback = rsp_fallback_ff;

endmodule

/* tb/sv/tb_voice_allocation_queue_top.sv */
// Self-checking testbench for voice_allocation_queue_top: directed and random requests,
// predicted per chip and compared per field. Depends on vaq_pkg, vaq_req_if,
// vaq_rsp_if and voice_allocation_queue_top.
`timescale 1ns / 1ps

module tb_voice_allocation_queue_top;

   typedef struct packed {
      vaq_pkg::action_type action;
      logic [1:0]          chip;
      logic [7:0]          instrument;
      logic [7:0]          assign_mode;
      logic [3:0]          voice_count;
      logic [2:0]          target_voice;
   } request_type;

   typedef struct packed {
      logic [2:0] voice;
      logic       fallback;
   } response_type;

   // Tracks every chip's voice queue and the responses still owed by the block.
   class allocation_tracker;
      vaq_pkg::entry_type rows[vaq_pkg::CHIPS][vaq_pkg::VOICES];
      response_type       owed_responses[$];
      int                 failures;

      function new();
         failures = 0;
         for (int c = 0; c < vaq_pkg::CHIPS; c++) begin
            for (int i = 0; i < vaq_pkg::VOICES; i++) begin
               rows[c][i].voice      = 3'(i);
               rows[c][i].assigned   = 1'b0;
               rows[c][i].exclusive  = 1'b0;
               rows[c][i].instrument = vaq_pkg::NO_INSTRUMENT;
            end
         end
      endfunction

      function int pending();
         return owed_responses.size();
      endfunction

      function int find_entry(int c, logic [2:0] v);
         for (int i = 0; i < vaq_pkg::VOICES; i++)
            if (rows[c][i].voice == v)
               return i;
         return -1;
      endfunction

      function void move_to_back(int c, int pos, vaq_pkg::entry_type e);
         for (int j = pos; j < vaq_pkg::VOICES - 1; j++)
            rows[c][j] = rows[c][j + 1];
         rows[c][vaq_pkg::VOICES - 1] = e;
      endfunction

      function bit pick_voice(int c, logic [7:0] instr, logic [7:0] asg,
                              logic [3:0] raw_count, output logic [2:0] voice);
         int                 cnt;
         logic [7:0]         left_mask;
         logic [7:0]         allowed;
         vaq_pkg::entry_type e;
         cnt = (raw_count > vaq_pkg::VOICES) ? vaq_pkg::VOICES : int'(raw_count);
         if (cnt == 0)
            cnt = 1;
         left_mask = 8'((1 << (vaq_pkg::VOICES / 2)) - 1);
         case (asg)
            vaq_pkg::ASG_ALL:   allowed = 8'((1 << vaq_pkg::VOICES) - 1);
            vaq_pkg::ASG_LEFT:  allowed = left_mask;
            vaq_pkg::ASG_RIGHT: allowed = (cnt <= vaq_pkg::VOICES / 2) ? left_mask
                                          : left_mask << (vaq_pkg::VOICES / 2);
            default:            allowed = 8'(1) <<
                                   ((int'(asg) - int'(vaq_pkg::ASG_DEDICATED)) % cnt);
         endcase
         voice = 3'd0;
         for (int i = 0; i < vaq_pkg::VOICES; i++) begin
            e = rows[c][i];
            if (allowed[e.voice] &&
                (!e.exclusive || e.instrument == instr || asg >= vaq_pkg::ASG_DEDICATED)) begin
               e.assigned   = 1'b1;
               e.exclusive  = (asg >= vaq_pkg::ASG_DEDICATED);
               e.instrument = instr;
               move_to_back(c, i, e);
               voice = e.voice;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // Apply one accepted request to the queues and queue up its response.
      function response_type note_request(request_type r);
         response_type       res;
         bit                 ok;
         int                 c;
         int                 pos;
         logic [2:0]         v;
         vaq_pkg::entry_type e;
         ok = 1'b0;
         v  = 3'd0;
         c  = int'(r.chip);
         if (c < vaq_pkg::CHIPS) begin
            case (r.action)
               vaq_pkg::ACT_GET: begin
                  ok = pick_voice(c, r.instrument, r.assign_mode, r.voice_count, v);
               end
               vaq_pkg::ACT_GET_LAST: begin
                  pos = find_entry(c, r.target_voice);
                  if (pos >= 0 && rows[c][pos].instrument == r.instrument &&
                      rows[c][pos].voice < r.voice_count) begin
                     e = rows[c][pos];
                     e.assigned = 1'b1;
                     move_to_back(c, pos, e);
                     v  = e.voice;
                     ok = 1'b1;
                  end else begin
                     ok = pick_voice(c, r.instrument, r.assign_mode, r.voice_count, v);
                  end
               end
               vaq_pkg::ACT_RELEASE: begin
                  pos = find_entry(c, r.target_voice);
                  if (pos >= 0) begin
                     rows[c][pos].assigned = 1'b0;
                     v  = r.target_voice;
                     ok = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         res.voice    = ok ? v : 3'd0;
         res.fallback = !ok;
         owed_responses.push_back(res);
         return res;
      endfunction

      function void check_response(logic [2:0] voice, logic fallback);
         response_type want;
         if (owed_responses.size() == 0) begin
            $error("response with no request outstanding: voice %0d fallback %0d",
                   voice, fallback);
            failures++;
            return;
         end
         want = owed_responses.pop_front();
         if (voice !== want.voice) begin
            $error("field voice: expected %0d, actual %0d", want.voice, voice);
            failures++;
         end
         if (fallback !== want.fallback) begin
            $error("field fallback: expected %0d, actual %0d", want.fallback, fallback);
            failures++;
         end
      endfunction
   endclass

   localparam int DRAIN_LIMIT = 5000;
   localparam int SETTLE      = 12;
   localparam int PHASE_ITEMS = 400;
   localparam int LONG_HOLD   = 200;

   logic clock;
   logic reset;

   vaq_req_if req_ch ();
   vaq_rsp_if rsp_ch ();

   voice_allocation_queue_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   allocation_tracker tracker = new();

   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;

   // Last voice handed out per chip and the instrument that got it; steer
   // get-last and release requests toward voices that are really in use.
   logic [2:0] recent_voice[vaq_pkg::CHIPS];
   logic [7:0] recent_instr[vaq_pkg::CHIPS];

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // Response side: drop ready at random per cycle, or hold it low for a
   // requested number of cycles so the block backs up into the request side.
   initial begin : response_sink
      int hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Check every response transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         tracker.check_response(rsp_ch.voice, rsp_ch.fallback);
   end

   function automatic request_type make_request(vaq_pkg::action_type a, int chip,
                                                int instr, int asg, int cnt,
                                                int target);
      request_type r;
      r.action       = a;
      r.chip         = 2'(chip);
      r.instrument   = 8'(instr);
      r.assign_mode  = 8'(asg);
      r.voice_count  = 4'(cnt);
      r.target_voice = 3'(target);
      return r;
   endfunction

   // Mostly small instrument numbers so that exclusivity and reuse collide
   // often; now and then fully random fields to toggle every bit.
   function automatic request_type random_request();
      request_type r;
      int          pick;
      int          c;
      c      = $urandom_range(0, vaq_pkg::CHIPS - 1);
      r.chip = 2'(c);
      pick   = $urandom_range(0, 99);
      if (pick < 40)
         r.action = vaq_pkg::ACT_GET;
      else if (pick < 70)
         r.action = vaq_pkg::ACT_GET_LAST;
      else if (pick < 95)
         r.action = vaq_pkg::ACT_RELEASE;
      else
         r.action = vaq_pkg::ACT_NONE;

      pick = $urandom_range(0, 9);
      if (pick == 0)
         r.instrument = 8'($urandom);
      else if (pick < 3)
         r.instrument = vaq_pkg::NO_INSTRUMENT;
      else
         r.instrument = 8'($urandom_range(0, 3));

      pick = $urandom_range(0, 99);
      if (pick < 30)
         r.assign_mode = vaq_pkg::ASG_ALL;
      else if (pick < 45)
         r.assign_mode = vaq_pkg::ASG_LEFT;
      else if (pick < 60)
         r.assign_mode = vaq_pkg::ASG_RIGHT;
      else if (pick < 90)
         r.assign_mode = 8'($urandom_range(3, 12));
      else
         r.assign_mode = 8'($urandom);

      pick = $urandom_range(0, 99);
      if (pick < 50)
         r.voice_count = 4'(vaq_pkg::VOICES);
      else if (pick < 65)
         r.voice_count = 4'($urandom_range(0, 3));
      else
         r.voice_count = 4'($urandom);

      r.target_voice = 3'($urandom);
      if (r.action == vaq_pkg::ACT_GET_LAST && $urandom_range(0, 9) < 6) begin
         r.target_voice = recent_voice[c];
         if ($urandom_range(0, 9) < 7)
            r.instrument = recent_instr[c];
      end else if (r.action == vaq_pkg::ACT_RELEASE && $urandom_range(0, 1) == 1) begin
         r.target_voice = recent_voice[c];
      end
      return r;
   endfunction

   // Offer one transaction, idling first at the current rate, and hold it
   // until the block takes it.
   task automatic send_request(request_type r);
      response_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.action       <= r.action;
      req_ch.chip         <= r.chip;
      req_ch.instrument   <= r.instrument;
      req_ch.assign_mode  <= r.assign_mode;
      req_ch.voice_count  <= r.voice_count;
      req_ch.target_voice <= r.target_voice;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      res = tracker.note_request(r);
      if (!res.fallback && r.action != vaq_pkg::ACT_RELEASE) begin
         recent_voice[r.chip] = res.voice;
         recent_instr[r.chip] = r.instrument;
      end
   endtask

   // Hold off until every predicted response is back, then let the block settle.
   task automatic wait_for_responses();
      int waited;
      waited = 0;
      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.action       <= vaq_pkg::ACT_GET;
      req_ch.chip         <= 2'd0;
      req_ch.instrument   <= vaq_pkg::NO_INSTRUMENT;
      req_ch.assign_mode  <= vaq_pkg::ASG_ALL;
      req_ch.voice_count  <= 4'd0;
      req_ch.target_voice <= 3'd0;
      hold_request  = 0;
      send_idle_pct = 18;
      recv_idle_pct = 72;
      for (int c = 0; c < vaq_pkg::CHIPS; c++) begin
         recent_voice[c] = 3'd0;
         recent_instr[c] = vaq_pkg::NO_INSTRUMENT;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every mode, the field extremes and the corner cases.
      send_request(make_request(vaq_pkg::ACT_GET, 0, 0, vaq_pkg::ASG_ALL, vaq_pkg::VOICES, 0));
      send_request(make_request(vaq_pkg::ACT_GET, 0, 255, vaq_pkg::ASG_LEFT, 15, 0));
      send_request(make_request(vaq_pkg::ACT_GET, 0, 1, vaq_pkg::ASG_RIGHT, vaq_pkg::VOICES,
                                0));
      // right half with few voices falls back to the left half (mono)
      send_request(make_request(vaq_pkg::ACT_GET, 0, 1, vaq_pkg::ASG_RIGHT, 2, 0));
      // count of zero acts as one; top assign mode with count clamped
      send_request(make_request(vaq_pkg::ACT_GET, 2, 5, 255, 0, 0));
      send_request(make_request(vaq_pkg::ACT_GET, 2, 6, 255, 15, 0));
      // get-last: reuse, instrument mismatch, voice absent, voice beyond count
      send_request(make_request(vaq_pkg::ACT_GET_LAST, 2, 6, vaq_pkg::ASG_ALL,
                                vaq_pkg::VOICES, 0));
      send_request(make_request(vaq_pkg::ACT_GET_LAST, 2, 7, vaq_pkg::ASG_ALL,
                                vaq_pkg::VOICES, 0));
      send_request(make_request(vaq_pkg::ACT_GET_LAST, 2, 7, vaq_pkg::ASG_LEFT,
                                vaq_pkg::VOICES, 7));
      send_request(make_request(vaq_pkg::ACT_GET_LAST, 2, 7, vaq_pkg::ASG_ALL, 3, 5));
      // release present and absent voices, and the unused action code
      send_request(make_request(vaq_pkg::ACT_RELEASE, 2, 0, vaq_pkg::ASG_ALL, 0, 0));
      send_request(make_request(vaq_pkg::ACT_RELEASE, 2, 0, vaq_pkg::ASG_ALL, 0, 6));
      send_request(make_request(vaq_pkg::ACT_RELEASE, 3, 255, 255, 15, 7));
      send_request(make_request(vaq_pkg::ACT_NONE, 3, 0, vaq_pkg::ASG_ALL, vaq_pkg::VOICES,
                                0));
      // lock the left half to one instrument, then let another one ask
      send_request(make_request(vaq_pkg::ACT_GET, 1, 1, 3, vaq_pkg::VOICES, 0));
      send_request(make_request(vaq_pkg::ACT_GET, 1, 1, 4, vaq_pkg::VOICES, 0));
      send_request(make_request(vaq_pkg::ACT_GET, 1, 1, 5, vaq_pkg::VOICES, 0));
      send_request(make_request(vaq_pkg::ACT_GET, 1, 2, vaq_pkg::ASG_LEFT, vaq_pkg::VOICES,
                                0));
      send_request(make_request(vaq_pkg::ACT_GET, 1, 1, vaq_pkg::ASG_LEFT, vaq_pkg::VOICES,
                                0));
      send_request(make_request(vaq_pkg::ACT_GET, 1, 2, vaq_pkg::ASG_RIGHT, 1, 0));
      send_request(make_request(vaq_pkg::ACT_GET_LAST, 1, 1, vaq_pkg::ASG_ALL, 15, 1));
      send_request(make_request(vaq_pkg::ACT_GET, 3, 128, 200, 9, 0));

      // Random, phase one: sender idles lightly, receiver heavily.
      repeat (PHASE_ITEMS) send_request(random_request());
      wait_for_responses();

      // Phase two: swap the idle rates.
      send_idle_pct = 72;
      recv_idle_pct = 18;
      repeat (PHASE_ITEMS) send_request(random_request());
      wait_for_responses();

      // Phase three: no idling, but start with a long receiver stall so the
      // block fills up and stops taking requests.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = LONG_HOLD;
      repeat (PHASE_ITEMS) send_request(random_request());
      wait_for_responses();

      if (tracker.pending() != 0) begin
         $error("%0d responses never arrived", tracker.pending());
         tracker.failures++;
      end
      if (tracker.failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* files.f */
rtl/vaq_pkg.sv
rtl/vaq_req_if.sv
rtl/vaq_rsp_if.sv
rtl/voice_allocation_queue_top.sv
tb/sv/tb_voice_allocation_queue_top.sv
